// ===== hw/rtl/wbps_pkg.sv =====
package wbps_pkg;

    // Widths fixed by the register map and the item fields.
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_INDEX_W       = 3;
    localparam int PATTERN_LENGTH_W  = 5;
    localparam int REG_PATTERN_BYTES = 16;
    localparam int MATCH_OFFSET_W    = 32;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LOW     = 3'd0,
        CFG_PATTERN_HIGH    = 3'd1,
        CFG_PATTERN_LENGTH  = 3'd2,
        CFG_IGNORE_BYTE     = 3'd3,
        CFG_WILDCARD_ENABLE = 3'd4
    } cfg_index_t;

    typedef logic [7:0] byte_t;

    // Per-cell compare setup, derived from the configuration registers.
    typedef struct packed {
        logic  care;
        logic  wild;
        byte_t pattern;
    } cell_setup_t;

endpackage

// ===== hw/rtl/wbps_if.sv =====
interface wbps_in_if
    import wbps_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t data_byte;
    logic  last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_out_if
    import wbps_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      found;
    logic [MATCH_OFFSET_W-1:0] match_offset;

    modport source (output valid, output found, output match_offset, input ready);
    modport sink   (input valid, input found, input match_offset, output ready);
endinterface

// ===== hw/rtl/wbps_cell.sv =====
module wbps_cell
    import wbps_pkg::*;
(
    input  logic        clk,
    input  logic        shift_en,
    input  cell_setup_t setup,
    input  byte_t       byte_in,
    output byte_t       byte_out,
    output logic        hit
);

    byte_t window_reg;

    // The compare looks at the byte about to be stored, so the decision
    // belongs to the item that is being accepted in this cycle. A cell that
    // is not part of the pattern, or that holds a wildcard slot, always hits.
    always_comb
    begin
        hit = !setup.care || setup.wild || (byte_in == setup.pattern);
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            window_reg <= byte_in;
        end
    end

    assign byte_out = window_reg;

endmodule

// ===== hw/rtl/wildcard_byte_pattern_search.sv =====
// Channel   Role     Payload                       Handshake
// in_ch     sink     data_byte[7:0], last_byte     valid / ready
// out_ch    source   found, match_offset[31:0]     valid / ready
// cfg       write    cfg_index[2:0], cfg_data[63:0] cfg_en, no back-pressure
//
// One item is accepted per cycle while in_ch.ready is high; its result, if any,
// appears in the output register on the following cycle. Every cell compares
// and shifts in the same cycle that an item is accepted.
// Reset (rst_n low, asynchronous) clears the configuration registers, the
// byte count, the reported flag and the output valid. The window bytes are
// not reset: a compare only counts once the byte count covers the pattern,
// so no clearing pass is needed.
// in_ch.ready drops only while a result waits in the output register and the
// sink is not taking it.
module wildcard_byte_pattern_search
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = 16,
    parameter int OFFSET_BITS       = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    wbps_in_if.sink                in_ch,
    wbps_out_if.source             out_ch,
    input  logic                   cfg_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CAP = (MAX_PATTERN_BYTES < REG_PATTERN_BYTES)
                         ? MAX_PATTERN_BYTES : REG_PATTERN_BYTES;
    localparam logic [PATTERN_LENGTH_W-1:0] CAP_LEN = PATTERN_LENGTH_W'(CAP);
    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = {OFFSET_BITS{1'b1}};

    // Configuration registers.
    logic [CFG_DATA_W-1:0]       pattern_low_reg;
    logic [CFG_DATA_W-1:0]       pattern_high_reg;
    logic [PATTERN_LENGTH_W-1:0] pattern_length_reg;
    byte_t                       ignore_byte_reg;
    logic                        wildcard_enable_reg;

    // Search state and output register.
    logic [OFFSET_BITS-1:0]    count_reg;
    logic [OFFSET_BITS-1:0]    count_next;
    logic                      reported_reg;
    logic                      reported_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      found_reg;
    logic                      found_next;
    logic [MATCH_OFFSET_W-1:0] offset_reg;
    logic [MATCH_OFFSET_W-1:0] offset_next;

    logic                            accept;
    logic [PATTERN_LENGTH_W-1:0]     len_eff;
    logic [REG_PATTERN_BYTES-1:0][7:0] pattern_bytes;
    logic [MAX_PATTERN_BYTES-1:0]    hits;
    byte_t [MAX_PATTERN_BYTES-1:0]   window;
    logic                            match_now;
    logic [OFFSET_BITS-1:0]          offset_diff;
    logic [MATCH_OFFSET_W-1:0]       offset_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg     <= '0;
            pattern_high_reg    <= '0;
            pattern_length_reg  <= PATTERN_LENGTH_W'(1);
            ignore_byte_reg     <= '0;
            wildcard_enable_reg <= 1'b0;
        end
        else if (cfg_en)
        begin
            case (cfg_index)
                CFG_PATTERN_LOW:     pattern_low_reg     <= cfg_data;
                CFG_PATTERN_HIGH:    pattern_high_reg    <= cfg_data;
                CFG_PATTERN_LENGTH:  pattern_length_reg  <= cfg_data[PATTERN_LENGTH_W-1:0];
                CFG_IGNORE_BYTE:     ignore_byte_reg     <= cfg_data[7:0];
                CFG_WILDCARD_ENABLE: wildcard_enable_reg <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // A zero length counts as one byte; a length beyond the cell chain or the
    // register map is clipped to the shorter of the two.
    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            len_eff = PATTERN_LENGTH_W'(1);
        end
        else if (pattern_length_reg > CAP_LEN)
        begin
            len_eff = CAP_LEN;
        end
        else
        begin
            len_eff = pattern_length_reg;
        end
    end

    assign pattern_bytes = {pattern_high_reg, pattern_low_reg};

    // An output register parts the two sides: a new item is taken while the
    // previous result is being handed over.
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    // The cell chain. Cell j holds the byte that arrived j items ago and
    // compares it against pattern byte len-1-j, which lines the oldest byte
    // of the window up with the first pattern byte.
    for (genvar j = 0; j < MAX_PATTERN_BYTES; j++)
    begin : g_cell
        cell_setup_t setup;
        byte_t       byte_in;
        logic [PATTERN_LENGTH_W-1:0] pidx;

        if (j < CAP)
        begin : g_used
            assign pidx          = len_eff - PATTERN_LENGTH_W'(j) - PATTERN_LENGTH_W'(1);
            assign setup.care    = PATTERN_LENGTH_W'(j) < len_eff;
            assign setup.pattern = pattern_bytes[pidx[3:0]];
            assign setup.wild    = wildcard_enable_reg && (setup.pattern == ignore_byte_reg);
        end
        else
        begin : g_spare
            assign pidx          = '0;
            assign setup.care    = 1'b0;
            assign setup.pattern = pidx[0] ? 8'hFF : 8'h00;
            assign setup.wild    = 1'b0;
        end

        if (j == 0)
        begin : g_head
            assign byte_in = in_ch.data_byte;
        end
        else
        begin : g_link
            assign byte_in = window[j-1];
        end

        wbps_cell u_cell (
            .clk      (clk),
            .shift_en (accept),
            .setup    (setup),
            .byte_in  (byte_in),
            .byte_out (window[j]),
            .hit      (hits[j])
        );
    end

    // The byte count saturates; the match needs at least len bytes so that
    // only bytes of the current buffer take part in the compare.
    always_comb
    begin
        if (count_reg == COUNT_MAX)
        begin
            count_next = count_reg;
        end
        else
        begin
            count_next = count_reg + OFFSET_BITS'(1);
        end
    end

    assign match_now   = !reported_reg && (count_next >= OFFSET_BITS'(len_eff)) && (&hits);
    assign offset_diff = count_next - OFFSET_BITS'(len_eff);

    if (OFFSET_BITS >= MATCH_OFFSET_W)
    begin : g_off_trunc
        assign offset_now = offset_diff[MATCH_OFFSET_W-1:0];
    end
    else
    begin : g_off_ext
        assign offset_now = {{(MATCH_OFFSET_W-OFFSET_BITS){1'b0}}, offset_diff};
    end

    always_comb
    begin
        reported_next  = reported_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        found_next     = found_reg;
        offset_next    = offset_reg;
        if (accept)
        begin
            if (match_now)
            begin
                reported_next  = 1'b1;
                out_valid_next = 1'b1;
                found_next     = 1'b1;
                offset_next    = offset_now;
            end
            else if (in_ch.last_byte && !reported_reg)
            begin
                out_valid_next = 1'b1;
                found_next     = 1'b0;
                offset_next    = '0;
            end
            if (in_ch.last_byte)
            begin
                reported_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            reported_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            reported_reg  <= reported_next;
            if (accept)
            begin
                count_reg <= in_ch.last_byte ? '0 : count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg  <= found_next;
        offset_reg <= offset_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.found        = found_reg;
    assign out_ch.match_offset = offset_reg;

    // The last byte of a buffer leaves the count and the reported flag clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.last_byte) |=> (count_reg == '0) && !reported_reg)
        else $error("state not cleared after the last byte");

    // A buffer that ends with no match reported always yields an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.last_byte && !reported_reg) |=> out_valid_reg)
        else $error("last byte gave no result");

    // A reported match inside a buffer blocks further results.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && match_now && !in_ch.last_byte) |=> reported_reg && found_reg)
        else $error("match not recorded as reported");

endmodule
